// File: rtl/bus_pkg.sv
// ----------------------------------------------------------------------------
// bus_pkg - shared types and constants for the bounded unique set
// Request kinds, port widths, default sizes and the per-cell control word.
// ----------------------------------------------------------------------------
package bus_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int ITEM_WIDTH_DEF = 32;

	localparam int KIND_W  = 2;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD      = 2'd0,
		KIND_REMOVE   = 2'd1,
		KIND_CONTAINS = 2'd2,
		KIND_CLEAR    = 2'd3
	} kind_t;

	// ins: every cell takes its left neighbour's entry (new value enters cell 0)
	// del: cells at and beyond the hit take their right neighbour's entry
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

// File: rtl/bounded_unique_set_top.sv
// ----------------------------------------------------------------------------
// bounded_unique_set_top - set of up to CAPACITY distinct values
// A row of slot cells with a live count and a registered result word.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid / in_stall with kind and value. A word is taken
//   on a rising edge with in_valid high and in_stall low. kind selects add,
//   remove, contains or clear; value is cut to ITEM_WIDTH bits.
//   Result channel: out_valid / out_stall with success, count and empty_res.
//   Exactly one result word per request, in request order.
//   Result: registered; it shows in the cycle after the request is taken.
//   Throughput: one request per cycle while in_stall is low. All cells compare
//   the value and the row shifts by one slot in the same cycle, so the compare
//   across the row and the hit chain along it set the cycle time.
//   Stall: the result register holds while out_stall is high; a new request
//   is still taken in the cycle the held word is taken, otherwise in_stall
//   rises until it leaves.
//   Reset (arst_n low): count goes to zero and no result is pending. The slot
//   contents are not cleared; only slots below the count are ever compared.
//   Order inside the store is kept, newest first: add pushes at slot 0, remove
//   closes the gap by shifting the tail down one slot.
// ----------------------------------------------------------------------------
module bounded_unique_set_top #(
	parameter int CAPACITY   = bus_pkg::CAPACITY_DEF,
	parameter int ITEM_WIDTH = bus_pkg::ITEM_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bus_pkg::KIND_W-1:0]   kind,
	input  logic [bus_pkg::VALUE_W-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         success,
	output logic [bus_pkg::COUNT_W-1:0]  count,
	output logic                         empty_res
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                  accept;
	bus_pkg::kind_t        req_kind;
	logic [ITEM_WIDTH-1:0] req_item;

	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cnt_next;
	logic                  ok;
	logic                  found;

	logic [ITEM_WIDTH-1:0] item_arr [CAPACITY];
	logic [CAPACITY-1:0]   match_vec;
	logic [CAPACITY:0]     hit_chain;

	bus_pkg::cell_ctrl_t   ctrl;

	logic                  out_valid_q;
	logic                  success_q;
	logic [CNT_W-1:0]      res_cnt_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign req_kind = bus_pkg::kind_t'(kind);
	assign req_item = ITEM_WIDTH'(value);

	// hit chain runs along the row; its far end says the value is live
	assign hit_chain[0] = 1'b0;
	assign found        = hit_chain[CAPACITY];

	// request decode and next count
	always_comb begin
		ctrl     = '0;
		ok       = 1'b0;
		cnt_next = cnt_q;
		unique case (req_kind)
			bus_pkg::KIND_ADD: begin
				if ((cnt_q < CNT_W'(CAPACITY)) && !found) begin
					ok       = 1'b1;
					ctrl.ins = accept;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			bus_pkg::KIND_REMOVE: begin
				if (found) begin
					ok       = 1'b1;
					ctrl.del = accept;
					cnt_next = cnt_q - CNT_W'(1);
				end
			end
			bus_pkg::KIND_CONTAINS: begin
				ok = found;
			end
			bus_pkg::KIND_CLEAR: begin
				ok       = 1'b1;
				cnt_next = '0;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// row of slot cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_WIDTH-1:0] left_item;
		logic [ITEM_WIDTH-1:0] right_item;

		if (i == 0) begin : g_head
			assign left_item = req_item;
		end else begin : g_body
			assign left_item = item_arr[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_item = item_arr[i];
		end else begin : g_inner
			assign right_item = item_arr[i+1];
		end

		bus_cell #(
			.ITEM_WIDTH (ITEM_WIDTH),
			.CNT_W      (CNT_W),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.cnt        (cnt_q),
			.req_item   (req_item),
			.left_item  (left_item),
			.right_item (right_item),
			.hit_in     (hit_chain[i]),
			.item_q     (item_arr[i]),
			.match      (match_vec[i]),
			.hit_out    (hit_chain[i+1])
		);
	end

	// count and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			success_q <= ok;
			res_cnt_q <= cnt_next;
		end
	end

	assign out_valid = out_valid_q;
	assign success   = success_q;
	assign count     = bus_pkg::COUNT_W'({{bus_pkg::COUNT_W{1'b0}}, res_cnt_q});
	assign empty_res = (res_cnt_q == '0);

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("live count above capacity");

	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("value live in more than one slot");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_kind == bus_pkg::KIND_CLEAR) |=> (cnt_q == '0 && success_q))
		else $error("clear left entries live");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_kind == bus_pkg::KIND_ADD) |=>
			(success_q == (cnt_q == $past(cnt_q) + CNT_W'(1))))
		else $error("add result disagrees with count change");

	a_contains_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_kind == bus_pkg::KIND_CONTAINS) |=> $stable(cnt_q))
		else $error("lookup changed the count");

endmodule

// File: rtl/bus_cell.sv
// ----------------------------------------------------------------------------
// bus_cell - one slot of the set store
// Holds one entry, compares it with the request and shifts with its neighbours.
// ----------------------------------------------------------------------------
module bus_cell #(
	parameter int ITEM_WIDTH = bus_pkg::ITEM_WIDTH_DEF,
	parameter int CNT_W      = bus_pkg::COUNT_W,
	parameter int INDEX      = 0
) (
	input  logic                   clk,
	input  bus_pkg::cell_ctrl_t    ctrl,
	input  logic [CNT_W-1:0]       cnt,
	input  logic [ITEM_WIDTH-1:0]  req_item,
	input  logic [ITEM_WIDTH-1:0]  left_item,
	input  logic [ITEM_WIDTH-1:0]  right_item,
	input  logic                   hit_in,
	output logic [ITEM_WIDTH-1:0]  item_q,
	output logic                   match,
	output logic                   hit_out
);

	logic live;

	// slot is live while its index is below the count
	assign live    = CNT_W'(INDEX) < cnt;
	assign match   = live && (item_q == req_item);
	assign hit_out = hit_in | match;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			item_q <= left_item;
		end else if (ctrl.del && hit_out) begin
			item_q <= right_item;
		end
	end

endmodule

// File: dv/bounded_unique_set_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_unique_set_checker - result scoreboard for the bounded unique set
// Watches both channels, keeps its own copy of the set to predict each
// result word, and compares field by field in request order.
// ----------------------------------------------------------------------------
module bounded_unique_set_checker
	import bus_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [KIND_W-1:0]  kind,
	input  logic [VALUE_W-1:0] value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               success,
	input  logic [COUNT_W-1:0] count,
	input  logic               empty_res,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic               success;
		logic [COUNT_W-1:0] count;
		logic               empty_res;
	} set_result_t;

	logic [VALUE_W-1:0] live_value [CAPACITY];
	int                 live_size;
	set_result_t        result_q [$];

	task automatic report_mismatch(string what, int exp_val, int got_val);
		$display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_val, got_val);
		fail_count++;
	endtask

	// lowest live slot holding v, or -1
	function automatic int find_live(logic [VALUE_W-1:0] v);
		for (int i = 0; i < live_size; i++)
			if (live_value[i] == v)
				return i;
		return -1;
	endfunction

	// apply one request to the shadow set and return its result word
	function automatic set_result_t apply_request(kind_t k, logic [VALUE_W-1:0] v);
		set_result_t r;
		int          hit;
		hit       = find_live(v);
		r.success = 1'b0;
		case (k)
			KIND_ADD: begin
				if (live_size < CAPACITY && hit < 0) begin
					live_value[live_size] = v;
					live_size++;
					r.success = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (hit >= 0) begin
					live_size--;
					live_value[hit] = live_value[live_size];
					r.success = 1'b1;
				end
			end
			KIND_CONTAINS: r.success = (hit >= 0);
			default: begin
				live_size = 0;
				r.success = 1'b1;
			end
		endcase
		r.count     = live_size[COUNT_W-1:0];
		r.empty_res = (live_size == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		set_result_t exp_r;
		set_result_t new_r;
		if (!arst_n) begin
			live_size = 0;
			result_q.delete();
			pending = 0;
		end else begin
			// result first: the result word is registered, so it never belongs to this edge's request
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					report_mismatch("result word with nothing expected", 0, 1);
				end else begin
					exp_r = result_q.pop_front();
					if (success !== exp_r.success)
						report_mismatch("success", int'(exp_r.success), int'(success));
					if (count !== exp_r.count)
						report_mismatch("count", int'(exp_r.count), int'(count));
					if (empty_res !== exp_r.empty_res)
						report_mismatch("empty_res", int'(exp_r.empty_res),
							int'(empty_res));
				end
			end
			if (in_valid && !in_stall) begin
				new_r = apply_request(kind_t'(kind), value);
				result_q.insert(result_q.size(), new_r);
			end
			pending = result_q.size();
		end
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the bounded unique set
// Directed corner requests, then bursts of random requests drawn mostly from
// a small value pool so that duplicates, hits and a full set are common.
// The result side stalls on a shifting pattern; a checker scores the words.
// ----------------------------------------------------------------------------
module tb_top;
	import bus_pkg::*;

	localparam int N_RANDOM   = 1025;
	localparam int POOL_SIZE  = 24;
	localparam int IDLE_LIMIT = 3000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [KIND_W-1:0]  kind = KIND_ADD;
	logic [VALUE_W-1:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               success;
	logic [COUNT_W-1:0] count;
	logic               empty_res;

	int fail_count;
	int pending;

	logic [VALUE_W-1:0] value_pool [POOL_SIZE];

	always #5 clk = ~clk;

	bounded_unique_set_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.success   (success),
		.count     (count),
		.empty_res (empty_res)
	);

	bounded_unique_set_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.success    (success),
		.count      (count),
		.empty_res  (empty_res),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Result-side back-pressure: whenever the 6-bit phase wraps to zero, a new 16-bit
	// stall pattern is picked - none, sparse, even or dense - and played out cycle by cycle.
	logic [15:0] stall_pat = '0;
	logic [5:0]  stall_phase = '0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_phase == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pat = '0;
					1: stall_pat = 16'($urandom);
					2: stall_pat = 16'($urandom & $urandom);
					default: stall_pat = 16'($urandom | $urandom);
				endcase
			end
			out_stall   <= stall_pat[stall_phase[3:0]];
			stall_phase <= stall_phase + 6'd1;
		end
	end

	// Watchdog: counts edges at which neither channel moves a word.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Present one request word at the falling edge and hold it until taken.
	// valid stays high between back-to-back words.
	task automatic send_word(kind_t k, logic [VALUE_W-1:0] v);
		@(negedge clk);
		in_valid <= 1'b1;
		kind     <= k;
		value    <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic refill_pool();
		value_pool[0] = '0;
		value_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;
	endtask

	function automatic kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return KIND_CLEAR;
		else if (r < 48)
			return KIND_ADD;
		else if (r < 73)
			return KIND_REMOVE;
		return KIND_CONTAINS;
	endfunction

	initial begin
		int                 sent;
		int                 burst;
		int                 gap;
		logic [VALUE_W-1:0] v;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty set, both value extremes, duplicate and absent values
		send_word(KIND_REMOVE, 32'h0000_0007);    // remove on an empty set
		send_word(KIND_CONTAINS, 32'h0000_0000);
		send_word(KIND_ADD, 32'h0000_0000);
		send_word(KIND_ADD, 32'hFFFF_FFFF);
		send_word(KIND_ADD, 32'h0000_0000);       // duplicate add
		send_word(KIND_CONTAINS, 32'hFFFF_FFFF);
		send_word(KIND_REMOVE, 32'h0001_2345);    // remove of an absent value
		// fill to capacity, then one add too many
		for (int i = 0; i < CAPACITY_DEF - 2; i++)
			send_word(KIND_ADD, 32'hA5A5_0000 + i);
		send_word(KIND_ADD, 32'h5A5A_5A5A);       // full set
		send_word(KIND_REMOVE, 32'hA5A5_0000 + CAPACITY_DEF - 3);  // newest value, held in slot 0
		send_word(KIND_REMOVE, 32'h0000_0000);    // oldest value, in the last live slot
		send_word(KIND_CLEAR, 32'hDEAD_BEEF);
		send_word(KIND_CONTAINS, 32'hFFFF_FFFF);  // gone after clear

		// random bursts, mostly pool values so the set fills and hits are common
		refill_pool();
		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst; i++) begin
				if ($urandom_range(0, 99) < 85)
					v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					v = $urandom;
				send_word(pick_kind(), v);
				sent++;
				if (sent % 200 == 0)
					refill_pool();
			end
			// a quarter of bursts run straight into the next one
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then wait on to catch any stray word
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
